// ===== rtl/core/mpfa_pkg.sv =====
package mpfa_pkg;

	localparam int unsigned WordW = 64;

	typedef logic [WordW-1:0] word_t;

	// operation codes carried in the kind field
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_NEG = 3'd2,
		OP_MUL = 3'd3,
		OP_INV = 3'd4,
		OP_LEG = 3'd5,
		OP_RS6 = 3'd6,
		OP_RS7 = 3'd7
	} op_t;

	// configuration register indexes
	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_MINV    = 2'd1;
	localparam logic [1:0] REG_ONE     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIMPLE,
		ST_MUL,
		ST_SQR,
		ST_SQR_WAIT,
		ST_MULA,
		ST_MULA_WAIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture operands and opcode
		logic simple;    // compute add/sub/neg/reserved result into acc
		logic mul_ab;    // start a*b
		logic pow_init;  // acc <= Montgomery one, exponent chosen
		logic sqr;       // start acc*acc
		logic mula;      // start acc*a
		logic finish;    // compute flag, present result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mul_done;
		logic exp_bit;
	} sts_t;

endpackage

// ===== rtl/core/mpfa_datapath.sv =====
module mpfa_datapath
	import mpfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  word_t      cfg_data,
	input  logic [2:0] kind,
	input  word_t      operand_a,
	input  word_t      operand_b,
	input  cmd_t       cmd,
	input  logic [5:0] bit_idx,
	output sts_t       sts,
	output word_t      result,
	output logic       non_residue
);

	word_t modulus_q, minv_q, one_q;
	word_t a_q, b_q, acc_q, exp_q;
	op_t   op_q;
	logic  flag_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= '0;
			minv_q    <= '0;
			one_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODULUS: modulus_q <= cfg_data;
				REG_MINV:    minv_q    <= cfg_data;
				REG_ONE:     one_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic word_t cred(word_t v, word_t p);
		return (v < p) ? v : v - p;
	endfunction

	// add, sub, neg
	word_t add_s, sub_d, sub_s, neg_r, simple_r;
	logic  add_c;
	always_comb begin
		{add_c, add_s} = {1'b0, a_q} + {1'b0, b_q};
		if (add_c) add_s = add_s + one_q;
		sub_d = a_q - b_q;
		if (a_q < b_q) sub_d = sub_d - one_q;
		sub_s = cred(cred(sub_d, modulus_q), modulus_q);
		neg_r = cred(modulus_q - a_q, modulus_q);
		unique case (op_q)
			OP_ADD:  simple_r = cred(add_s, modulus_q);
			OP_SUB:  simple_r = sub_s;
			OP_NEG:  simple_r = neg_r;
			default: simple_r = '0;
		endcase
	end

	// Montgomery multiplier: up to four 32x32 partial products per phase
	logic [2:0]  mph_q;
	logic        mbusy_q;
	word_t       mx_q, my_q, hi_q, m_q;
	logic [63:0] pp00_q, pp01_q, pp10_q, pp11_q;
	logic [63:0] mid_c, lo_c, hi_c;
	always_comb begin
		mid_c = {32'd0, pp00_q[63:32]} + {32'd0, pp01_q[31:0]} + {32'd0, pp10_q[31:0]};
		lo_c  = {mid_c[31:0], pp00_q[31:0]};
		hi_c  = pp11_q + {32'd0, pp01_q[63:32]} + {32'd0, pp10_q[63:32]}
			+ {32'd0, mid_c[63:32]};
	end

	logic  mstart;
	word_t ms_x, ms_y;
	always_comb begin
		mstart = cmd.mul_ab | cmd.sqr | cmd.mula;
		ms_x = cmd.mul_ab ? a_q : acc_q;
		ms_y = cmd.mul_ab ? b_q : (cmd.sqr ? acc_q : a_q);
	end

	word_t mres;
	always_comb mres = (hi_q - hi_c) + ((hi_q < hi_c) ? modulus_q : '0);

	// phases: 0 pp(x,y); 1 sum -> hi,lo; pp(lo,minv); 2 sum -> m=lo*minv (low 64);
	// 3 pp(m,p); 4 sum -> mhi, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mph_q   <= '0;
		end else if (mstart) begin
			mbusy_q <= 1'b1;
			mph_q   <= 3'd0;
		end else if (mbusy_q) begin
			mph_q <= mph_q + 3'd1;
			if (mph_q == 3'd4) mbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mstart) begin
			mx_q <= ms_x;
			my_q <= ms_y;
		end else if (mbusy_q) begin
			unique case (mph_q)
				3'd0: begin
					pp00_q <= {32'd0, mx_q[31:0]}  * {32'd0, my_q[31:0]};
					pp01_q <= {32'd0, mx_q[31:0]}  * {32'd0, my_q[63:32]};
					pp10_q <= {32'd0, mx_q[63:32]} * {32'd0, my_q[31:0]};
					pp11_q <= {32'd0, mx_q[63:32]} * {32'd0, my_q[63:32]};
				end
				3'd1: begin
					hi_q <= hi_c;
					pp00_q <= {32'd0, lo_c[31:0]}  * {32'd0, minv_q[31:0]};
					pp01_q <= {32'd0, lo_c[31:0]}  * {32'd0, minv_q[63:32]};
					pp10_q <= {32'd0, lo_c[63:32]} * {32'd0, minv_q[31:0]};
					pp11_q <= '0;
				end
				3'd2: begin
					m_q <= lo_c;
				end
				3'd3: begin
					pp00_q <= {32'd0, m_q[31:0]}  * {32'd0, modulus_q[31:0]};
					pp01_q <= {32'd0, m_q[31:0]}  * {32'd0, modulus_q[63:32]};
					pp10_q <= {32'd0, m_q[63:32]} * {32'd0, modulus_q[31:0]};
					pp11_q <= {32'd0, m_q[63:32]} * {32'd0, modulus_q[63:32]};
				end
				default: ;
			endcase
		end
	end
	assign sts.mul_done = mbusy_q && (mph_q == 3'd4);

	// operand, accumulator and exponent registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q  <= operand_a;
			b_q  <= operand_b;
			op_q <= op_t'(kind);
		end
		if (cmd.pow_init) begin
			acc_q <= one_q;
			exp_q <= (op_q == OP_INV) ? modulus_q - 64'd2 : (modulus_q - 64'd1) >> 1;
		end else if (cmd.simple) begin
			acc_q <= simple_r;
		end else if (sts.mul_done) begin
			acc_q <= mres;
		end
		// legendre always finishes on a multiply, so the fresh product is compared
		if (cmd.finish) begin
			flag_q <= (op_q == OP_LEG) && (mres == cred(modulus_q - one_q, modulus_q));
		end
	end
	assign sts.exp_bit = exp_q[bit_idx];

	assign result      = acc_q;
	assign non_residue = flag_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(mstart && mbusy_q)) else $error("multiplier restarted while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |=> !mbusy_q) else $error("multiplier did not go idle");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		mstart |=> mbusy_q && mph_q == 3'd0) else $error("multiplier start lost");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load |-> !mbusy_q)) else $error("load during multiply");

endmodule

// ===== rtl/core/mpfa_ctrl.sv =====
module mpfa_ctrl
	import mpfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] kind,
	input  logic       in_fire,
	input  logic       out_fire,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic [5:0] bit_idx,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_d;
	logic [5:0] bit_q, bit_d;
	op_t op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			op_q    <= OP_ADD;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
			if (in_fire) op_q <= op_t'(kind);
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		bit_d   = bit_q;
		cmd     = '0;
		cmd.load = in_fire;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_SIMPLE;
			end
			ST_SIMPLE: begin
				unique case (op_q)
					OP_MUL: begin
						cmd.mul_ab = 1'b1;
						state_d = ST_MUL;
					end
					OP_INV, OP_LEG: begin
						cmd.pow_init = 1'b1;
						bit_d = 6'd63;
						state_d = ST_SQR;
					end
					default: begin
						cmd.simple = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_MUL: begin
				if (sts.mul_done) state_d = ST_DONE;
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				state_d = ST_SQR_WAIT;
			end
			ST_SQR_WAIT: begin
				if (sts.mul_done) begin
					if (sts.exp_bit) state_d = ST_MULA;
					else if (bit_q == 6'd0) state_d = ST_DONE;
					else begin
						bit_d = bit_q - 6'd1;
						state_d = ST_SQR;
					end
				end
			end
			ST_MULA: begin
				cmd.mula = 1'b1;
				state_d = ST_MULA_WAIT;
			end
			ST_MULA_WAIT: begin
				if (sts.mul_done) begin
					if (bit_q == 6'd0) state_d = ST_DONE;
					else begin
						bit_d = bit_q - 6'd1;
						state_d = ST_SQR;
					end
				end
			end
			ST_DONE: begin
				if (out_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if ((state_q == ST_MUL || state_q == ST_SQR_WAIT || state_q == ST_MULA_WAIT)
			&& sts.mul_done && state_d == ST_DONE)
			cmd.finish = 1'b1;
		if (state_q == ST_SIMPLE && state_d == ST_DONE)
			cmd.finish = 1'b1;
	end

	assign bit_idx = bit_q;
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	a_fire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE) else $error("beat taken while busy");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_fire) |=> done) else $error("result dropped");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.simple, cmd.mul_ab, cmd.pow_init, cmd.sqr, cmd.mula}))
		else $error("conflicting commands");

endmodule

// ===== rtl/core/montgomery_prime_field_alu_top.sv =====
// channel | signals                           | contents
// s_axis  | s_tvalid s_tready s_tdata[135:0]  | kind, operand_a, operand_b
// m_axis  | m_tvalid m_tready m_tdata[71:0]   | result, non_residue
// config  | cfg_we cfg_idx[1:0] cfg_data[63:0] | modulus, modulus_inverse, r_mod_p
// Add, sub, neg go from ST_SIMPLE to ST_DONE; mul also waits in ST_MUL for the multiplier.
// Inv and legendre run a square per exponent bit and a multiply per one bit in the exponent,
// each on the shared five-phase Montgomery multiplier used per square/multiply.
// One item at a time; s_tready is low until the result beat is taken.
// arst_n clears control and configuration registers; configuration must be loaded.
module montgomery_prime_field_alu_top
	import mpfa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // [2:0] kind, [66:3] operand_a, [130:67] operand_b
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // [63:0] result, [64] non_residue
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [63:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic [5:0] bit_idx;
	logic busy, done, in_fire, out_fire, nr;
	word_t res;

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = done;
	assign out_fire = m_tvalid && m_tready;
	assign m_tdata  = {7'd0, nr, res};

	mpfa_ctrl u_ctrl (
		.clk, .arst_n, .kind(s_tdata[2:0]), .in_fire, .out_fire, .sts, .cmd,
		.bit_idx, .busy, .done
	);

	mpfa_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.kind(s_tdata[2:0]), .operand_a(s_tdata[66:3]), .operand_b(s_tdata[130:67]),
		.cmd, .bit_idx, .sts, .result(res), .non_residue(nr)
	);

endmodule

// ===== dv/tb_montgomery_prime_field_alu_top.sv =====
module tb_montgomery_prime_field_alu_top;
	import mpfa_pkg::*;

	typedef struct {
		op_t   kind;
		word_t a;
		word_t b;
	} op_beat_t;

	typedef struct {
		word_t value;
		logic  qnr;
	} field_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_idx;
	logic [63:0]  cfg_data;

	op_beat_t   pending_ops[$];
	op_beat_t   expected_q_in[$];
	field_res_t expected_res[$];
	bit         s_tready_seen;
	int         n_errors;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_cycles;

	// shadow copy of the configuration
	word_t p_mod;
	word_t p_minv;
	word_t p_one;

	montgomery_prime_field_alu_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// field arithmetic in Montgomery form
	function automatic word_t cond_sub_p(word_t v);
		return (v < p_mod) ? v : v - p_mod;
	endfunction

	function automatic word_t mont_mul(word_t x, word_t y);
		logic [127:0] prod;
		logic [127:0] mp;
		word_t        m;
		word_t        c;
		prod = x * y;
		m = prod[63:0] * p_minv;
		mp = m * p_mod;
		c = prod[127:64] - mp[127:64];
		if (prod[127:64] < mp[127:64])
			c = c + p_mod;
		return c;
	endfunction

	function automatic word_t mont_pow(word_t x, word_t e);
		word_t r;
		r = p_one;
		for (int i = 63; i >= 0; i--) begin
			r = mont_mul(r, r);
			if (e[i])
				r = mont_mul(r, x);
		end
		return r;
	endfunction

	function automatic field_res_t alu_predict(op_beat_t t);
		field_res_t r;
		word_t      c;
		r.value = '0;
		r.qnr = 1'b0;
		case (t.kind)
			OP_ADD: begin
				c = t.a + t.b;
				if (c < t.a)
					c = c + p_one;
				r.value = cond_sub_p(c);
			end
			OP_SUB: begin
				c = t.a - t.b;
				if (t.a < t.b)
					c = c - p_one;
				r.value = cond_sub_p(cond_sub_p(c));
			end
			OP_NEG: r.value = cond_sub_p(p_mod - t.a);
			OP_MUL: r.value = mont_mul(t.a, t.b);
			OP_INV: r.value = mont_pow(t.a, p_mod - 64'd2);
			OP_LEG: begin
				r.value = mont_pow(t.a, (p_mod - 64'd1) >> 1);
				r.qnr = (r.value == cond_sub_p(p_mod - p_one));
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		$display("mismatch %s: got %h want %h", what, got, want);
		n_errors++;
	endtask

	// driver: falling edge, fed from pending_ops
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready_seen) begin
			if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				op_beat_t t;
				t = pending_ops.pop_front();
				s_tdata <= {5'd0, t.b, t.a, t.kind};
				s_tvalid <= 1'b1;
				expected_q_in.push_back(t);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// acceptance of the input beat, sampled at the rising edge
	always @(posedge clk) begin
		s_tready_seen <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			expected_res.push_back(alu_predict(expected_q_in.pop_front()));
	end

	// receiver readiness, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata[63:0], '0);
			end else begin
				field_res_t w;
				w = expected_res.pop_front();
				if (m_tdata[63:0] !== w.value)
					report_mismatch("result", m_tdata[63:0], w.value);
				if (m_tdata[64] !== w.qnr)
					report_mismatch("non_residue", {63'd0, m_tdata[64]}, {63'd0, w.qnr});
			end
		end
	end

	function automatic word_t rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// random element, usually below p, sometimes anything
	function automatic word_t rand_elem();
		word_t v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			2: v = p_mod - 64'd1;
			3: v = p_one;
			default: begin
				v = rand_word();
				if ($urandom_range(9) != 0)
					while (v >= p_mod) v = v - p_mod;
			end
		endcase
		return v;
	endfunction

	task automatic push_op(op_t k, word_t a, word_t b);
		op_beat_t t;
		t.kind = k;
		t.a = a;
		t.b = b;
		pending_ops.push_back(t);
	endtask

	task automatic wait_drained();
		while (pending_ops.size() > 0 || expected_q_in.size() > 0 || s_tvalid
		       || expected_res.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, word_t v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// load a modulus with its Montgomery constants
	task automatic load_modulus(word_t p);
		word_t inv;
		logic [127:0] r;
		inv = 64'd1;
		for (int i = 0; i < 6; i++)
			inv = inv * (64'd2 - p * inv);
		r = {64'd1, 64'd0} % {64'd0, p};
		p_mod = p;
		p_minv = inv;
		p_one = r[63:0];
		write_reg(REG_MODULUS, p_mod);
		write_reg(REG_MINV, p_minv);
		write_reg(REG_ONE, p_one);
	endtask

	task automatic random_ops(int n);
		op_t k;
		for (int i = 0; i < n; i++) begin
			k = op_t'($urandom_range(7));
			// keep exponentiations to about one in twelve
			if ((k == OP_INV || k == OP_LEG) && $urandom_range(2) != 0)
				k = op_t'($urandom_range(3));
			push_op(k, rand_elem(), rand_elem());
		end
	endtask

	task automatic run_phase(int idle, int stall, int n);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		random_ops(n);
		wait_drained();
	endtask

	initial begin
		word_t primes[4];
		primes[0] = 64'hFFFF_FFFF_FFFF_FFC5;
		primes[1] = 64'hFFFF_FFFF_0000_0001;
		primes[2] = 64'h8000_0000_0000_001D;
		primes[3] = 64'hFFFF_FFFF_FFFF_FFA3;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MODULUS;
		cfg_data = '0;
		n_errors = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		p_mod = '0;
		p_minv = '0;
		p_one = '0;

		// unloaded registers: cheap operations only
		push_op(OP_ADD, '1, 64'd1);
		push_op(OP_MUL, 64'd3, 64'd5);
		push_op(OP_RS6, '1, '1);
		wait_drained();

		load_modulus(primes[0]);
		// directed: extremes, every op, zero inverse and legendre
		push_op(OP_ADD, p_mod - 64'd1, p_mod - 64'd1);
		push_op(OP_ADD, '1, '1);
		push_op(OP_ADD, '0, '0);
		push_op(OP_SUB, '0, p_mod - 64'd1);
		push_op(OP_SUB, '0, '1);
		push_op(OP_SUB, '1, '0);
		push_op(OP_NEG, '0, '0);
		push_op(OP_NEG, '1, '0);
		push_op(OP_MUL, '1, '1);
		push_op(OP_MUL, p_mod - 64'd1, p_mod - 64'd1);
		push_op(OP_INV, '0, '0);
		push_op(OP_INV, p_one, '0);
		push_op(OP_INV, rand_elem(), '0);
		push_op(OP_LEG, '0, '0);
		push_op(OP_LEG, cond_sub_p(p_mod - p_one), '0);
		push_op(OP_LEG, rand_elem(), '0);
		push_op(OP_LEG, rand_elem(), '0);
		push_op(OP_RS6, '1, '1);
		push_op(OP_RS7, '1, '1);
		wait_drained();

		run_phase(0, 0, 100);
		load_modulus(primes[1]);
		run_phase(66, 0, 90);

		// long receiver hold-off while short items keep coming
		hold_cycles = 400;
		for (int i = 0; i < 6; i++)
			push_op(OP_MUL, rand_elem(), rand_elem());
		wait_drained();

		load_modulus(primes[2]);
		run_phase(0, 66, 90);
		load_modulus(primes[3]);
		// unreduced registers: Montgomery one left at its extreme
		p_one = '1;
		write_reg(REG_ONE, p_one);
		run_phase(28, 28, 40);
		load_modulus(primes[0]);
		run_phase(28, 28, 60);

		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== montgomery_prime_field_alu_top.f =====
rtl/core/mpfa_pkg.sv
rtl/core/mpfa_datapath.sv
rtl/core/mpfa_ctrl.sv
rtl/core/montgomery_prime_field_alu_top.sv
dv/tb_montgomery_prime_field_alu_top.sv
